// ----- src/tiik_pkg.sv -----
package tiik_pkg;

    // Default CORDIC iteration count
    localparam int CORDIC_STEPS_DEF = 16;

    // CORDIC datapath width, angle width (radians * 2^24), multiplier operand width
    localparam int CW = 52;
    localparam int AW = 30;
    localparam int MW = 34;

    localparam logic signed [AW-1:0] HALF_PI_Q24 = 30'sd26353589;

    // Largest accepted step count
    localparam logic [6:0] STEP_MAX = 7'd64;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_UPPER = 2'd0,
        REG_LOWER = 2'd1,
        REG_STEPS = 2'd2,
        REG_NONE  = 2'd3
    } reg_idx_t;

    // atan(2^-i) in radians * 2^24
    function automatic logic signed [AW-1:0] atan_q24(input logic [4:0] i);
        logic signed [AW-1:0] r;
        case (i)
            5'd0:  r = 30'sd13176795;
            5'd1:  r = 30'sd7778716;
            5'd2:  r = 30'sd4110060;
            5'd3:  r = 30'sd2086331;
            5'd4:  r = 30'sd1047214;
            5'd5:  r = 30'sd524117;
            5'd6:  r = 30'sd262123;
            5'd7:  r = 30'sd131069;
            5'd8:  r = 30'sd65536;
            5'd9:  r = 30'sd32768;
            5'd10: r = 30'sd16384;
            5'd11: r = 30'sd8192;
            5'd12: r = 30'sd4096;
            5'd13: r = 30'sd2048;
            5'd14: r = 30'sd1024;
            5'd15: r = 30'sd512;
            5'd16: r = 30'sd256;
            5'd17: r = 30'sd128;
            5'd18: r = 30'sd64;
            5'd19: r = 30'sd32;
            5'd20: r = 30'sd16;
            5'd21: r = 30'sd8;
            5'd22: r = 30'sd4;
            5'd23: r = 30'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Saturate to 16 bits signed
    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'sd32767)
            r = 16'sd32767;
        else if (v < -32'sd32768)
            r = -16'sd32768;
        else
            r = v[15:0];
        return r;
    endfunction

    // Round Q24 radians to Q3.13 and saturate
    function automatic logic signed [15:0] q24_to_q13(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] t;
        t = (v + AW'(1024)) >>> 11;
        return sat16(32'(t));
    endfunction

endpackage

// ----- src/tiik_cordic.sv -----
module tiik_cordic #(
    parameter int CORDIC_STEPS = tiik_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [tiik_pkg::CW-1:0] x_in,
    input  logic signed [tiik_pkg::CW-1:0] y_in,
    output logic                          done,
    output logic signed [tiik_pkg::AW-1:0] ang
);
    import tiik_pkg::*;

    localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [IW-1:0] LAST = IW'(CORDIC_STEPS - 1);
    localparam logic [CW-1:0] NORM_LIM  = CW'(1) << 40;
    localparam logic [CW-1:0] SMALL_LIM = CW'(1) << 33;

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_NORM = 3'b010,
        C_ITER = 3'b100
    } cst_t;

    cst_t                  state_reg, state_next;
    logic signed [CW-1:0]  x_reg, x_next, y_reg, y_next;
    logic signed [AW-1:0]  ang_reg, ang_next;
    logic [IW-1:0]         iter_reg, iter_next;
    logic                  done_reg, done_next;
    logic [CW-1:0]         ax, ay;
    logic signed [CW-1:0]  sx, sy;

    assign ax = x_reg[CW-1] ? CW'(-x_reg) : CW'(x_reg);
    assign ay = y_reg[CW-1] ? CW'(-y_reg) : CW'(y_reg);
    assign sx = x_reg >>> iter_reg;
    assign sy = y_reg >>> iter_reg;

    // Normalise, fold into the right half plane, then rotate towards y = 0
    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        ang_next   = ang_reg;
        iter_next  = iter_reg;
        done_next  = 1'b0;
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    if (x_in == '0 && y_in == '0)
                    begin
                        ang_next  = '0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        x_next     = x_in;
                        y_next     = y_in;
                        state_next = C_NORM;
                    end
                end
            end
            C_NORM:
            begin
                if (ax < NORM_LIM && ay < NORM_LIM)
                begin
                    if (ax < SMALL_LIM && ay < SMALL_LIM)
                    begin
                        x_next = x_reg <<< 8;
                        y_next = y_reg <<< 8;
                    end
                    else
                    begin
                        x_next = x_reg <<< 1;
                        y_next = y_reg <<< 1;
                    end
                end
                else
                begin
                    iter_next  = '0;
                    state_next = C_ITER;
                    ang_next   = '0;
                    if (x_reg < 0)
                    begin
                        if (y_reg >= 0)
                        begin
                            x_next   = y_reg;
                            y_next   = -x_reg;
                            ang_next = HALF_PI_Q24;
                        end
                        else
                        begin
                            x_next   = -y_reg;
                            y_next   = x_reg;
                            ang_next = -HALF_PI_Q24;
                        end
                    end
                end
            end
            C_ITER:
            begin
                if (y_reg > 0)
                begin
                    x_next   = x_reg + sy;
                    y_next   = y_reg - sx;
                    ang_next = ang_reg + atan_q24(5'(iter_reg));
                end
                else
                begin
                    x_next   = x_reg - sy;
                    y_next   = y_reg + sx;
                    ang_next = ang_reg - atan_q24(5'(iter_reg));
                end
                if (iter_reg == LAST)
                begin
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end
                else
                begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        ang_reg  <= ang_next;
        iter_reg <= iter_next;
    end

    assign done = done_reg;
    assign ang  = ang_reg;

endmodule

// ----- src/tiik_sqrt.sv -----
module tiik_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] rad_in,
    output logic        done,
    output logic [31:0] root
);
    import tiik_pkg::*;

    localparam int RW = 36;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [63:0]   rad_reg, rad_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [31:0]   root_reg, root_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic [RW-1:0] rem_sh, trial;
    logic          ge;

    // Two radicand bits per step, one root bit out (floored)
    assign rem_sh = {rem_reg[RW-3:0], rad_reg[63:62]};
    assign trial  = RW'({root_reg, 2'b01});
    assign ge     = rem_sh >= trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                rad_next  = rad_in;
                rem_next  = '0;
                root_next = '0;
                cnt_next  = '0;
            end
        end
        else
        begin
            rad_next  = rad_reg << 2;
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            root_next = {root_reg[30:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- src/two_link_ik_interpolator.sv -----
// Two-link planar arm inverse kinematics with joint-space interpolation.
// Input channel (in_valid/in_ready): kind 0 loads the measured joint angles,
// kind 1 is a control tick. A tick taken while no move is running latches
// the target x, y, z, solves the joint angles and the per-tick increments,
// then advances the first tick. Every input transfer yields one result on
// the output channel (out_valid/out_ready).
// Config port (cfg_write/cfg_index/cfg_data): link lengths and step count,
// to be written only while the block is idle; the block does not enforce it.
// A measure item goes through S_OUT to the output register, a tick during a
// move through S_ADV and S_OUT; in_ready returns as the result is loaded.
// A new reachable target passes through the shared 34x34 multiplier (ten
// products), the 32-step square root, three CORDIC passes of CORDIC_STEPS
// iterations with their normalising shifts and two 16-step divisions; an
// unreachable one goes to S_OUT after the reach test.
// One item is in work at a time; in_ready is high only in S_IDLE.
// Reset loads the default registers, clears the angles and marks the arm
// ready for a target. If the receiver stalls, the result waits in the output
// register; one more item may be taken and worked, and it then holds in
// S_OUT with in_ready low until the waiting result is taken.
module two_link_ik_interpolator #(
    parameter int CORDIC_STEPS = tiik_pkg::CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [14:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic signed [15:0] target_x,
    input  logic signed [15:0] target_y,
    input  logic signed [15:0] target_z,
    input  logic signed [15:0] measured_shoulder,
    input  logic signed [15:0] measured_elbow,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] shoulder_command,
    output logic signed [15:0] elbow_command,
    output logic signed [15:0] lift_command,
    output logic               move_done,
    output logic               unreachable
);
    import tiik_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL  = 9'b000000010,
        S_ACC  = 9'b000000100,
        S_SQRT = 9'b000001000,
        S_CORD = 9'b000010000,
        S_FIN  = 9'b000100000,
        S_DIV  = 9'b001000000,
        S_ADV  = 9'b010000000,
        S_OUT  = 9'b100000000
    } st_t;

    st_t                  state_reg, state_next;

    // Configuration
    logic [14:0]          l1_reg, l2_reg;
    logic [6:0]           steps_reg;
    logic [14:0]          l1_eff, l2_eff;
    logic [6:0]           n_eff;

    // Arm state
    logic signed [15:0]   cur_s_reg, cur_s_next, cur_e_reg, cur_e_next;
    logic signed [15:0]   fin_s_reg, fin_s_next;
    logic signed [15:0]   inc_s_reg, inc_s_next, inc_e_reg, inc_e_next;
    logic signed [15:0]   lift_reg, lift_next;
    logic [6:0]           ticks_reg, ticks_next;
    logic                 idle_reg, idle_next;

    // Result flags
    logic                 done_f_reg, done_f_next, unr_reg, unr_next;

    // Solver working registers
    logic signed [15:0]   tx_reg, tx_next, ty_reg, ty_next;
    logic signed [15:0]   fe_reg, fe_next;
    logic [3:0]           mstep_reg, mstep_next;
    logic signed [63:0]   p_reg, acc_reg, acc_next;
    logic signed [MW-1:0] num_reg, num_next, den_reg, den_next;
    logic [31:0]          s_reg, s_next;
    logic signed [CW-1:0] yb_reg, yb_next, xb_reg, xb_next;
    logic [1:0]           cidx_reg, cidx_next;
    logic                 cstart_reg, cstart_next, sqstart_reg, sqstart_next;
    logic [63:0]          rad_reg, rad_next;
    logic signed [AW-1:0] elb_reg, elb_next, ab_reg, ab_next, aa_reg, aa_next;

    // Divider
    logic                 dsel_reg, dsel_next, dneg_reg, dneg_next;
    logic [3:0]           dcnt_reg, dcnt_next;
    logic [15:0]          dq_reg, dq_next;
    logic [6:0]           drem_reg, drem_next;

    // Output register
    logic                 ov_reg, ov_next;
    logic signed [15:0]   os_reg, os_next, oe_reg, oe_next, ol_reg, ol_next;
    logic                 od_reg, od_next, ou_reg, ou_next;

    // Combinational helpers
    logic signed [MW-1:0]   ma, mb, un, den_new;
    logic signed [2*MW-1:0] prod;
    logic signed [CW-1:0]   cx, cy;
    logic                   c_done, sq_done;
    logic signed [AW-1:0]   c_ang;
    logic [31:0]            sq_root;
    logic signed [15:0]     fs_new, fe_new;
    logic signed [16:0]     diff_s, diff_e, qs, sum_s, sum_e;
    logic [7:0]             r_sh;
    logic                   dge;
    logic [15:0]            dq_step;
    logic signed [15:0]     q16, cs_new, ce_new;
    logic [6:0]             ticks_new;

    // Register value 0 reads as 1, step count clamps to 1..64
    assign l1_eff = (l1_reg == '0) ? 15'd1 : l1_reg;
    assign l2_eff = (l2_reg == '0) ? 15'd1 : l2_reg;
    assign n_eff  = (steps_reg == '0) ? 7'd1 :
                    ((steps_reg > STEP_MAX) ? STEP_MAX : steps_reg);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_reg    <= 15'd4301;
            l2_reg    <= 15'd4506;
            steps_reg <= 7'd10;
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(cfg_index))
                REG_UPPER: l1_reg    <= cfg_data;
                REG_LOWER: l2_reg    <= cfg_data;
                REG_STEPS: steps_reg <= cfg_data[6:0];
                default:   ;
            endcase
        end
    end

    // Shared multiplier operand select
    assign un = (num_reg < 0) ? -num_reg : num_reg;

    always_comb
    begin
        case (mstep_reg)
            4'd0:    begin ma = MW'(tx_reg); mb = MW'(tx_reg); end
            4'd1:    begin ma = MW'(ty_reg); mb = MW'(ty_reg); end
            4'd2:    begin ma = $signed(MW'(l1_eff)); mb = $signed(MW'(l1_eff)); end
            4'd3:    begin ma = $signed(MW'(l2_eff)); mb = $signed(MW'(l2_eff)); end
            4'd4:    begin ma = $signed(MW'(l1_eff)); mb = $signed(MW'(l2_eff)); end
            4'd5:    begin ma = den_reg; mb = den_reg; end
            4'd6:    begin ma = un; mb = un; end
            4'd7:    begin ma = $signed(MW'(l2_eff)); mb = $signed(MW'(s_reg)); end
            4'd8:    begin ma = $signed(MW'(l1_eff)); mb = den_reg; end
            4'd9:    begin ma = $signed(MW'(l2_eff)); mb = num_reg; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    assign prod = ma * mb;

    always_ff @(posedge clk)
    begin
        p_reg <= prod[63:0];
    end

    // CORDIC inputs by pass: elbow, shoulder offset, target direction
    always_comb
    begin
        case (cidx_reg)
            2'd0:    begin cx = CW'(num_reg); cy = $signed(CW'(s_reg)); end
            2'd1:    begin cx = xb_reg; cy = yb_reg; end
            default: begin cx = CW'(tx_reg); cy = CW'(ty_reg); end
        endcase
    end

    tiik_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cstart_reg),
        .x_in  (cx),
        .y_in  (cy),
        .done  (c_done),
        .ang   (c_ang)
    );

    tiik_sqrt u_sqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sqstart_reg),
        .rad_in (rad_reg),
        .done   (sq_done),
        .root   (sq_root)
    );

    // Datapath helpers
    assign den_new = MW'(p_reg <<< 1);
    assign fe_new  = q24_to_q13(elb_reg);
    assign fs_new  = q24_to_q13(-(aa_reg + ab_reg));
    assign diff_s  = 17'(fs_new) - 17'(cur_s_reg);
    assign diff_e  = 17'(fe_reg) - 17'(cur_e_reg);
    assign r_sh    = {drem_reg, dq_reg[15]};
    assign dge     = r_sh >= {1'b0, n_eff};
    assign dq_step = {dq_reg[14:0], dge};
    assign qs      = dneg_reg ? -$signed(17'(dq_step)) : $signed(17'(dq_step));
    assign q16     = sat16(32'(qs));
    assign sum_s   = 17'(cur_s_reg) + 17'(inc_s_reg);
    assign sum_e   = 17'(cur_e_reg) + 17'(inc_e_reg);
    assign cs_new  = sat16(32'(sum_s));
    assign ce_new  = sat16(32'(sum_e));
    assign ticks_new = (ticks_reg < 7'd127) ? ticks_reg + 1'b1 : ticks_reg;

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        cur_s_next   = cur_s_reg;
        cur_e_next   = cur_e_reg;
        fin_s_next   = fin_s_reg;
        inc_s_next   = inc_s_reg;
        inc_e_next   = inc_e_reg;
        lift_next    = lift_reg;
        ticks_next   = ticks_reg;
        idle_next    = idle_reg;
        done_f_next  = done_f_reg;
        unr_next     = unr_reg;
        tx_next      = tx_reg;
        ty_next      = ty_reg;
        fe_next      = fe_reg;
        mstep_next   = mstep_reg;
        acc_next     = acc_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        s_next       = s_reg;
        yb_next      = yb_reg;
        xb_next      = xb_reg;
        cidx_next    = cidx_reg;
        cstart_next  = 1'b0;
        sqstart_next = 1'b0;
        rad_next     = rad_reg;
        elb_next     = elb_reg;
        ab_next      = ab_reg;
        aa_next      = aa_reg;
        dsel_next    = dsel_reg;
        dneg_next    = dneg_reg;
        dcnt_next    = dcnt_reg;
        dq_next      = dq_reg;
        drem_next    = drem_reg;
        ov_next      = ov_reg;
        os_next      = os_reg;
        oe_next      = oe_reg;
        ol_next      = ol_reg;
        od_next      = od_reg;
        ou_next      = ou_reg;

        // Output transfer
        if (ov_reg && out_ready)
            ov_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unr_next = 1'b0;
                    if (!kind)
                    begin
                        cur_s_next  = measured_shoulder;
                        cur_e_next  = measured_elbow;
                        done_f_next = idle_reg;
                        state_next  = S_OUT;
                    end
                    else if (idle_reg)
                    begin
                        lift_next  = target_z;
                        tx_next    = target_x;
                        ty_next    = target_y;
                        mstep_next = '0;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_ADV;
                    end
                end
            end
            S_MUL:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                mstep_next = mstep_reg + 1'b1;
                state_next = S_MUL;
                case (mstep_reg)
                    4'd0: acc_next = p_reg;
                    4'd1: acc_next = acc_reg + p_reg;
                    4'd2: acc_next = acc_reg - p_reg;
                    4'd3: num_next = MW'(acc_reg - p_reg);
                    4'd4:
                    begin
                        den_next = den_new;
                        // Reach test, exact
                        if (num_reg > den_new || num_reg < -den_new)
                        begin
                            unr_next    = 1'b1;
                            done_f_next = 1'b1;
                            state_next  = S_OUT;
                        end
                    end
                    4'd5: acc_next = p_reg;
                    4'd6:
                    begin
                        rad_next     = acc_reg - p_reg;
                        sqstart_next = 1'b1;
                        state_next   = S_SQRT;
                    end
                    4'd7: yb_next = CW'(p_reg);
                    4'd8: xb_next = CW'(p_reg);
                    4'd9:
                    begin
                        xb_next     = xb_reg + CW'(p_reg);
                        cidx_next   = 2'd0;
                        cstart_next = 1'b1;
                        state_next  = S_CORD;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_SQRT:
            begin
                if (sq_done)
                begin
                    s_next     = sq_root;
                    state_next = S_MUL;
                end
            end
            S_CORD:
            begin
                if (c_done)
                begin
                    case (cidx_reg)
                        2'd0:
                        begin
                            elb_next    = c_ang;
                            cidx_next   = 2'd1;
                            cstart_next = 1'b1;
                        end
                        2'd1:
                        begin
                            ab_next     = c_ang;
                            cidx_next   = 2'd2;
                            cstart_next = 1'b1;
                        end
                        default:
                        begin
                            aa_next    = c_ang;
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_FIN:
            begin
                fe_next    = fe_new;
                fin_s_next = fs_new;
                dsel_next  = 1'b0;
                dcnt_next  = '0;
                drem_next  = '0;
                dneg_next  = diff_s < 0;
                dq_next    = (diff_s < 0) ? 16'(-diff_s) : 16'(diff_s);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // Restoring division by the step count, toward zero
                drem_next = dge ? 7'(r_sh - {1'b0, n_eff}) : r_sh[6:0];
                dq_next   = dq_step;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == 4'd15)
                begin
                    if (!dsel_reg)
                    begin
                        inc_s_next = q16;
                        dsel_next  = 1'b1;
                        dcnt_next  = '0;
                        drem_next  = '0;
                        dneg_next  = diff_e < 0;
                        dq_next    = (diff_e < 0) ? 16'(-diff_e) : 16'(diff_e);
                    end
                    else
                    begin
                        inc_e_next = q16;
                        ticks_next = '0;
                        idle_next  = 1'b0;
                        state_next = S_ADV;
                    end
                end
            end
            S_ADV:
            begin
                cur_s_next = cs_new;
                cur_e_next = ce_new;
                ticks_next = ticks_new;
                if (cs_new >= fin_s_reg || ticks_new > n_eff)
                begin
                    idle_next   = 1'b1;
                    done_f_next = 1'b1;
                end
                else
                begin
                    done_f_next = idle_reg;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    os_next    = cur_s_reg;
                    oe_next    = cur_e_reg;
                    ol_next    = lift_reg;
                    od_next    = done_f_reg;
                    ou_next    = unr_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and arm state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cur_s_reg   <= '0;
            cur_e_reg   <= '0;
            fin_s_reg   <= '0;
            inc_s_reg   <= '0;
            inc_e_reg   <= '0;
            lift_reg    <= '0;
            ticks_reg   <= '0;
            idle_reg    <= 1'b1;
            cstart_reg  <= 1'b0;
            sqstart_reg <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_s_reg   <= cur_s_next;
            cur_e_reg   <= cur_e_next;
            fin_s_reg   <= fin_s_next;
            inc_s_reg   <= inc_s_next;
            inc_e_reg   <= inc_e_next;
            lift_reg    <= lift_next;
            ticks_reg   <= ticks_next;
            idle_reg    <= idle_next;
            cstart_reg  <= cstart_next;
            sqstart_reg <= sqstart_next;
            ov_reg      <= ov_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        done_f_reg <= done_f_next;
        unr_reg    <= unr_next;
        tx_reg     <= tx_next;
        ty_reg     <= ty_next;
        fe_reg     <= fe_next;
        mstep_reg  <= mstep_next;
        acc_reg    <= acc_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        s_reg      <= s_next;
        yb_reg     <= yb_next;
        xb_reg     <= xb_next;
        cidx_reg   <= cidx_next;
        rad_reg    <= rad_next;
        elb_reg    <= elb_next;
        ab_reg     <= ab_next;
        aa_reg     <= aa_next;
        dsel_reg   <= dsel_next;
        dneg_reg   <= dneg_next;
        dcnt_reg   <= dcnt_next;
        dq_reg     <= dq_next;
        drem_reg   <= drem_next;
        os_reg     <= os_next;
        oe_reg     <= oe_next;
        ol_reg     <= ol_next;
        od_reg     <= od_next;
        ou_reg     <= ou_next;
    end

    assign in_ready         = (state_reg == S_IDLE);
    assign out_valid        = ov_reg;
    assign shoulder_command = os_reg;
    assign elbow_command    = oe_reg;
    assign lift_command     = ol_reg;
    assign move_done        = od_reg;
    assign unreachable      = ou_reg;

endmodule
